### hdl/kdr_pkg.sv
// ----------------------------------------------------------------------------
// kdr_pkg
// Shared types and constants of the keying duration recorder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package kdr_pkg;

    // Store size and field widths
    localparam int STORE_BYTES_DEF = 1024;
    localparam int ADDR_W          = 10;
    localparam int FREE_W          = 11;
    localparam int TIME_W          = 32;
    localparam int UNIT_W          = 16;
    localparam int MACRO_W         = 6;
    localparam int OP_W            = 3;

    // Divider widths: numerator is elapsed time plus half a unit
    localparam int NUM_W   = TIME_W + 1;
    localparam int DEN_W   = UNIT_W;
    localparam int UNITS_W = 12;

    // Operation codes
    localparam logic [OP_W-1:0] OP_START    = 3'd0;
    localparam logic [OP_W-1:0] OP_KEY_DOWN = 3'd1;
    localparam logic [OP_W-1:0] OP_KEY_UP   = 3'd2;
    localparam logic [OP_W-1:0] OP_MACRO    = 3'd3;
    localparam logic [OP_W-1:0] OP_STOP     = 3'd4;

    // Byte encodings
    localparam logic [7:0] FILL_SILENCE = 8'hbf;
    localparam logic [7:0] FILL_TONE    = 8'hff;
    localparam logic [7:0] TAG_SILENCE  = 8'h80;
    localparam logic [7:0] TAG_TONE     = 8'hc0;
    localparam logic [7:0] TAG_MACRO    = 8'h40;
    localparam logic [7:0] TERMINATOR   = 8'h00;

    // Timing thresholds in units, and the free-count ceiling
    localparam logic [UNITS_W-1:0] UNITS_PER_FILL = 12'd63;
    localparam logic [UNITS_W-1:0] UNITS_SAT      = 12'd4032;
    localparam logic [NUM_W-1:0]   LONG_PAUSE_MIN = 33'd70;
    localparam logic [FREE_W-1:0]  FREE_MAX       = 11'h7ff;

    localparam logic [UNIT_W-1:0]  UNIT_RESET     = 16'd60;

    // Divider request and response
    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [NUM_W-1:0] quot;
    } div_rsp_t;

endpackage

### hdl/kdr_ifs.sv
// ----------------------------------------------------------------------------
// kdr_ifs
// Valid/ready channels of the keying duration recorder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface kdr_key_if;
    import kdr_pkg::*;
    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     operation;
    logic [TIME_W-1:0]   now_ms;
    logic [ADDR_W-1:0]   start_addr;
    logic [FREE_W-1:0]   free_count;
    logic [MACRO_W-1:0]  macro_code;

    modport source (output valid, operation, now_ms, start_addr, free_count,
                    macro_code, input ready);
    modport sink   (input valid, operation, now_ms, start_addr, free_count,
                    macro_code, output ready);
endinterface

interface kdr_rec_if;
    import kdr_pkg::*;
    logic                valid;
    logic                ready;
    logic [ADDR_W-1:0]   write_addr;
    logic [7:0]          write_byte;
    logic [FREE_W-1:0]   free_left;
    logic                last;

    modport source (output valid, write_addr, write_byte, free_left, last,
                    input ready);
    modport sink   (input valid, write_addr, write_byte, free_left, last,
                    output ready);
endinterface

interface kdr_cfg_if;
    import kdr_pkg::*;
    logic                valid;
    logic                ready;
    logic [UNIT_W-1:0]   data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

### hdl/keying_duration_recorder_top.sv
// ----------------------------------------------------------------------------
// keying_duration_recorder_top
// Records key timing as tagged duration bytes for a byte store.
// ----------------------------------------------------------------------------
//  channel   dir   handshake      payload
//  key_in    in    valid/ready    operation, now_ms, start_addr, free_count,
//                                 macro_code
//  rec_out   out   valid/ready    write_addr, write_byte, free_left, last
//  cfg       in    valid/ready    data = unit_ticks (always ready)
//
//  Start and items that write nothing emit no beat.
//  A key transition with writes runs the serial divider (one quotient
//  bit per cycle) and then writes up to 64 bytes; macro and stop write one
//  byte each. key_in is held off until the last beat is loaded.
//  A stall on rec_out holds the sequencer; the last beat may wait in the
//  output register while the next item is taken.
//  Reset is asynchronous; unit_ticks returns to 60.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module keying_duration_recorder_top
    import kdr_pkg::*;
#(
    parameter int STORE_BYTES = STORE_BYTES_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    kdr_key_if.sink   key_in,
    kdr_rec_if.source rec_out,
    kdr_cfg_if.sink   cfg
);

    logic [UNIT_W-1:0] unit_ticks_reg;
    div_req_t          div_req;
    div_rsp_t          div_rsp;

    // Hold the unit length register
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            unit_ticks_reg <= UNIT_RESET;
        else if (cfg.valid && cfg.ready)
            unit_ticks_reg <= cfg.data;
    end

    kdr_seq #(
        .STORE_BYTES (STORE_BYTES)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .key_in     (key_in),
        .rec_out    (rec_out),
        .unit_ticks (unit_ticks_reg),
        .div_req    (div_req),
        .div_rsp    (div_rsp)
    );

    kdr_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

endmodule

### hdl/kdr_div.sv
// ----------------------------------------------------------------------------
// kdr_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kdr_div
    import kdr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DEN_W:0]   rem_reg;
    logic [NUM_W-1:0] quot_reg;
    logic [DEN_W-1:0] den_reg;

    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             fits;

    // Shift in one numerator bit and try the subtract
    always_comb
    begin
        trial = {rem_reg[DEN_W-1:0], quot_reg[NUM_W-1]};
        fits  = trial >= {1'b0, den_reg};
        diff  = trial - {1'b0, den_reg};
    end

    // Iterate over the numerator bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            quot_reg <= '0;
            den_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                rem_reg  <= '0;
                quot_reg <= req.num;
                den_reg  <= req.den;
            end
            else if (busy_reg)
            begin
                rem_reg  <= fits ? diff : trial;
                quot_reg <= {quot_reg[NUM_W-2:0], fits};
                cnt_reg  <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(NUM_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

endmodule

### hdl/kdr_seq.sv
// ----------------------------------------------------------------------------
// kdr_seq
// Recording sequencer: decodes items, drives the divider, emits store beats.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kdr_seq
    import kdr_pkg::*;
#(
    parameter int STORE_BYTES = STORE_BYTES_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    kdr_key_if.sink           key_in,
    kdr_rec_if.source         rec_out,
    input  logic [UNIT_W-1:0] unit_ticks,
    output div_req_t          div_req,
    input  div_rsp_t          div_rsp
);

    typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_EMIT, ST_ONE} state_t;

    localparam int           ROOM_W   = 17;
    localparam logic [ROOM_W-1:0] ROOM_TOP = ROOM_W'(STORE_BYTES - 1);

    state_t              state_reg;
    logic [TIME_W-1:0]   last_time_reg;
    logic                have_prev_reg;
    logic [ADDR_W-1:0]   write_ptr_reg;
    logic [FREE_W-1:0]   bytes_free_reg;
    logic                long_pause_reg;
    logic [ADDR_W-1:0]   word_start_reg;
    logic                recording_reg;
    logic                is_tone_reg;
    logic                sat_reg;
    logic [UNITS_W-1:0]  units_reg;
    logic [ADDR_W-1:0]   pend_addr_reg;
    logic [7:0]          pend_byte_reg;
    logic [FREE_W-1:0]   pend_free_reg;
    logic                out_valid_reg;
    logic [ADDR_W-1:0]   out_addr_reg;
    logic [7:0]          out_byte_reg;
    logic [FREE_W-1:0]   out_free_reg;
    logic                out_last_reg;

    logic                accept;
    logic                slot_free;
    logic [ROOM_W-1:0]   room;
    logic [FREE_W-1:0]   start_free;
    logic [ADDR_W-1:0]   grow;
    logic [FREE_W:0]     grown;
    logic [FREE_W-1:0]   mac_free;
    logic [DEN_W-1:0]    den;
    logic [TIME_W-1:0]   elapsed;
    logic                key_go;
    logic                is_filler;
    logic                final_beat;
    logic [7:0]          emit_byte;

    // Handshake
    always_comb
    begin
        key_in.ready = (state_reg == ST_IDLE);
        accept       = key_in.valid && key_in.ready;
        slot_free    = !out_valid_reg || rec_out.ready;
    end

    // Start budget: leave room for the terminator
    always_comb
    begin
        if ({7'b0, key_in.start_addr} <= ROOM_TOP)
            room = ROOM_TOP - {7'b0, key_in.start_addr};
        else
            room = '0;
        start_free = (room < {6'b0, key_in.free_count}) ? FREE_W'(room)
                                                         : key_in.free_count;
    end

    // Macro: reclaim the bytes of the current word
    always_comb
    begin
        grow     = write_ptr_reg - word_start_reg;
        grown    = {1'b0, bytes_free_reg} + {2'b0, grow};
        mac_free = grown[FREE_W] ? FREE_MAX : grown[FREE_W-1:0];
    end

    // Divider request for key transitions
    always_comb
    begin
        den     = (unit_ticks == '0) ? DEN_W'(1) : unit_ticks;
        elapsed = key_in.now_ms - last_time_reg;
        unique case (key_in.operation)
            OP_KEY_DOWN: key_go = (bytes_free_reg != '0) && have_prev_reg;
            OP_KEY_UP:   key_go = (bytes_free_reg != '0);
            default:     key_go = 1'b0;
        endcase
        div_req.start = accept && key_go;
        div_req.num   = {1'b0, elapsed} + NUM_W'(den[DEN_W-1:1]);
        div_req.den   = den;
    end

    // Emission: fillers per block of units, then the tag, till bytes run out
    always_comb
    begin
        is_filler  = (units_reg >= UNITS_PER_FILL)
                     && !(sat_reg && (units_reg == UNITS_PER_FILL));
        final_beat = !is_filler || (bytes_free_reg == FREE_W'(1));
        if (is_filler)
            emit_byte = is_tone_reg ? FILL_TONE : FILL_SILENCE;
        else
            emit_byte = (is_tone_reg ? TAG_TONE : TAG_SILENCE)
                        | {2'b0, units_reg[5:0]};
    end

    // Sequencer, recording state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            last_time_reg  <= '0;
            have_prev_reg  <= 1'b0;
            write_ptr_reg  <= '0;
            bytes_free_reg <= '0;
            long_pause_reg <= 1'b0;
            word_start_reg <= '0;
            recording_reg  <= 1'b0;
            is_tone_reg    <= 1'b0;
            sat_reg        <= 1'b0;
            units_reg      <= '0;
            pend_addr_reg  <= '0;
            pend_byte_reg  <= '0;
            pend_free_reg  <= '0;
            out_valid_reg  <= 1'b0;
            out_addr_reg   <= '0;
            out_byte_reg   <= '0;
            out_free_reg   <= '0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            // Raise valid when a beat is loaded, drop it once taken
            if (slot_free && (state_reg == ST_EMIT || state_reg == ST_ONE))
                out_valid_reg <= 1'b1;
            else if (rec_out.ready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        unique case (key_in.operation)
                            OP_START:
                            begin
                                write_ptr_reg  <= key_in.start_addr;
                                word_start_reg <= key_in.start_addr;
                                bytes_free_reg <= start_free;
                                long_pause_reg <= 1'b1;
                                recording_reg  <= 1'b1;
                                last_time_reg  <= '0;
                                have_prev_reg  <= 1'b0;
                            end
                            OP_KEY_DOWN:
                            begin
                                if (key_go)
                                begin
                                    is_tone_reg <= 1'b0;
                                    state_reg   <= ST_DIV;
                                end
                                last_time_reg <= key_in.now_ms;
                                have_prev_reg <= 1'b1;
                            end
                            OP_KEY_UP:
                            begin
                                if (key_go)
                                begin
                                    if (long_pause_reg)
                                    begin
                                        long_pause_reg <= 1'b0;
                                        word_start_reg <= write_ptr_reg;
                                    end
                                    is_tone_reg <= 1'b1;
                                    state_reg   <= ST_DIV;
                                end
                                last_time_reg <= key_in.now_ms;
                                have_prev_reg <= 1'b1;
                            end
                            OP_MACRO:
                            begin
                                if (recording_reg)
                                begin
                                    bytes_free_reg <= mac_free;
                                    pend_addr_reg  <= word_start_reg;
                                    pend_byte_reg  <= TAG_MACRO
                                                      | {2'b0, key_in.macro_code};
                                    pend_free_reg  <= mac_free;
                                    write_ptr_reg  <= word_start_reg + 1'b1;
                                    state_reg      <= ST_ONE;
                                end
                            end
                            OP_STOP:
                            begin
                                if (recording_reg)
                                begin
                                    pend_addr_reg <= write_ptr_reg;
                                    pend_byte_reg <= TERMINATOR;
                                    pend_free_reg <= '0;
                                    state_reg     <= ST_ONE;
                                end
                                recording_reg  <= 1'b0;
                                bytes_free_reg <= '0;
                            end
                            default:
                            begin
                                // Undefined operation: ignore
                            end
                        endcase
                    end
                end

                ST_DIV:
                begin
                    // Take the rounded unit count, saturate long durations
                    if (div_rsp.done)
                    begin
                        if (div_rsp.quot >= NUM_W'(UNITS_SAT))
                        begin
                            units_reg <= UNITS_SAT;
                            sat_reg   <= 1'b1;
                        end
                        else
                        begin
                            units_reg <= div_rsp.quot[UNITS_W-1:0];
                            sat_reg   <= 1'b0;
                        end
                        if (!is_tone_reg && (div_rsp.quot > LONG_PAUSE_MIN))
                            long_pause_reg <= 1'b1;
                        state_reg <= ST_EMIT;
                    end
                end

                ST_EMIT:
                begin
                    if (slot_free)
                    begin
                        out_addr_reg   <= write_ptr_reg;
                        out_byte_reg   <= emit_byte;
                        out_free_reg   <= bytes_free_reg - 1'b1;
                        out_last_reg   <= final_beat;
                        write_ptr_reg  <= write_ptr_reg + 1'b1;
                        bytes_free_reg <= bytes_free_reg - 1'b1;
                        if (is_filler)
                            units_reg <= units_reg - UNITS_PER_FILL;
                        if (final_beat)
                            state_reg <= ST_IDLE;
                    end
                end

                ST_ONE:
                begin
                    if (slot_free)
                    begin
                        out_addr_reg  <= pend_addr_reg;
                        out_byte_reg  <= pend_byte_reg;
                        out_free_reg  <= pend_free_reg;
                        out_last_reg  <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign rec_out.valid      = out_valid_reg;
    assign rec_out.write_addr = out_addr_reg;
    assign rec_out.write_byte = out_byte_reg;
    assign rec_out.free_left  = out_free_reg;
    assign rec_out.last       = out_last_reg;

    // A beat that leaves no free byte closes its item
    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_free_reg == '0) |-> out_last_reg)
        else $error("beat with no free bytes left is not marked last");

    // Emission only starts and continues with budget left
    a_emit_budget: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT |-> bytes_free_reg != '0)
        else $error("emitting with no free bytes");

    // The divider answers only while the sequencer waits for it
    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> state_reg == ST_DIV)
        else $error("divider result outside the divide wait");

    // No budget outside an open recording
    a_closed_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !recording_reg |-> bytes_free_reg == '0)
        else $error("free bytes while no recording is open");

endmodule

### bench/kdr_store_write_checker.sv
// ============================================================================
// kdr_store_write_checker
// Watches the key, record and config channels of the keying duration
// recorder, predicts every store write from the accepted key beats and
// compares each record beat field by field against the oldest prediction.
// ============================================================================
`timescale 1ns / 1ps

module kdr_store_write_checker
    import kdr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    kdr_key_if   key_mon,
    kdr_rec_if   rec_mon,
    kdr_cfg_if   cfg_mon,
    output int   fail_count,
    output int   writes_outstanding,
    output int   writes_checked,
    output int   items_taken
);

    localparam int FILLS_MAX   = 63;
    localparam int MAX_REPORTS = 40;

    typedef struct packed {
        logic [ADDR_W-1:0] write_addr;
        logic [7:0]        write_byte;
        logic [FREE_W-1:0] free_left;
        logic              last;
    } store_write_t;

    store_write_t      predicted_writes[$];

    // Shadow of the recorder state
    logic [UNIT_W-1:0] unit_ms;
    logic [TIME_W-1:0] last_edge_ms;
    logic              prev_seen;
    logic              open_rec;
    logic              pause_long;
    logic [ADDR_W-1:0] wr_ptr;
    logic [ADDR_W-1:0] word_addr;
    logic [FREE_W-1:0] room_left;

    // Rounded units since the previous key edge, time wrapping at 2^32
    function automatic logic [63:0] units_since_edge(input logic [TIME_W-1:0] now);
        logic [63:0]       unit;
        logic [TIME_W-1:0] diff;
        unit = (unit_ms == '0) ? 64'd1 : {48'b0, unit_ms};
        diff = now - last_edge_ms;
        return (unit / 2 + {32'b0, diff}) / unit;
    endfunction

    // Consume one free byte and queue its write
    task automatic take_byte(input logic [7:0] value);
        room_left = room_left - 1'b1;
        predicted_writes.push_back('{wr_ptr, value, room_left, 1'b0});
        wr_ptr = wr_ptr + 1'b1;
    endtask

    // Fillers per 63 units, then the tagged remainder if a byte is left
    task automatic record_duration(input logic [63:0] units, input logic [7:0] fill,
                                   input logic [7:0] tag);
        logic [63:0] fills;
        logic [63:0] rem;
        fills = units / UNITS_PER_FILL;
        rem   = units % UNITS_PER_FILL;
        if (fills > FILLS_MAX)
        begin
            fills = FILLS_MAX;
            rem   = FILLS_MAX;
        end
        while (room_left != '0 && fills != 0)
        begin
            take_byte(fill);
            fills = fills - 1;
        end
        if (room_left != '0)
            take_byte(tag | {2'b00, rem[5:0]});
    endtask

    task automatic predict_item(input logic [OP_W-1:0] op, input logic [TIME_W-1:0] now,
                                input logic [ADDR_W-1:0] saddr,
                                input logic [FREE_W-1:0] fcount,
                                input logic [MACRO_W-1:0] mnum);
        int                queued;
        int                room;
        int                grown;
        logic [63:0]       units;
        logic [ADDR_W-1:0] span;
        queued = predicted_writes.size();
        case (op)
            OP_START:
            begin
                room       = STORE_BYTES_DEF - 1 - int'(saddr);
                wr_ptr     = saddr;
                word_addr  = saddr;
                room_left  = (int'(fcount) < room) ? fcount : FREE_W'(room);
                pause_long = 1'b1;
                open_rec   = 1'b1;
                last_edge_ms = '0;
                prev_seen  = 1'b0;
            end
            OP_KEY_DOWN:
            begin
                if (room_left != '0 && prev_seen)
                begin
                    units = units_since_edge(now);
                    if (units > LONG_PAUSE_MIN)
                        pause_long = 1'b1;
                    record_duration(units, FILL_SILENCE, TAG_SILENCE);
                end
                last_edge_ms = now;
                prev_seen    = 1'b1;
            end
            OP_KEY_UP:
            begin
                if (room_left != '0)
                begin
                    if (pause_long)
                    begin
                        pause_long = 1'b0;
                        word_addr  = wr_ptr;
                    end
                    record_duration(units_since_edge(now), FILL_TONE, TAG_TONE);
                end
                last_edge_ms = now;
                prev_seen    = 1'b1;
            end
            OP_MACRO:
            begin
                if (open_rec)
                begin
                    span  = wr_ptr - word_addr;
                    grown = int'(room_left) + int'(span);
                    room_left = (grown > int'(FREE_MAX)) ? FREE_MAX : FREE_W'(grown);
                    predicted_writes.push_back('{word_addr, TAG_MACRO | {2'b00, mnum},
                                                 room_left, 1'b0});
                    wr_ptr = word_addr + 1'b1;
                end
            end
            OP_STOP:
            begin
                if (open_rec)
                    predicted_writes.push_back('{wr_ptr, TERMINATOR, '0, 1'b0});
                open_rec  = 1'b0;
                room_left = '0;
            end
            default:
            begin
            end
        endcase
        if (predicted_writes.size() > queued)
            predicted_writes[predicted_writes.size() - 1].last = 1'b1;
    endtask

    task automatic report_field(input string field, input int expected, input int actual);
        if (expected != actual)
        begin
            fail_count = fail_count + 1;
            if (fail_count <= MAX_REPORTS)
                $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                         $time, field, expected, actual);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        store_write_t oldest;
        if (!rst_n)
        begin
            predicted_writes.delete();
            unit_ms      = UNIT_RESET;
            last_edge_ms = '0;
            prev_seen    = 1'b0;
            open_rec     = 1'b0;
            pause_long   = 1'b0;
            wr_ptr       = '0;
            word_addr    = '0;
            room_left    = '0;
            fail_count   = 0;
            writes_checked     = 0;
            items_taken        = 0;
            writes_outstanding = 0;
        end
        else
        begin
            // Compare a record beat with the oldest prediction
            if (rec_mon.valid && rec_mon.ready)
            begin
                if (predicted_writes.size() == 0)
                begin
                    fail_count = fail_count + 1;
                    if (fail_count <= MAX_REPORTS)
                        $display("%0t ns: unexpected write, expected none, actual addr 0x%0h byte 0x%0h",
                                 $time, rec_mon.write_addr, rec_mon.write_byte);
                end
                else
                begin
                    oldest = predicted_writes.pop_front();
                    report_field("write_addr", oldest.write_addr, rec_mon.write_addr);
                    report_field("write_byte", oldest.write_byte, rec_mon.write_byte);
                    report_field("free_left", oldest.free_left, rec_mon.free_left);
                    report_field("last", oldest.last, rec_mon.last);
                    writes_checked = writes_checked + 1;
                end
            end

            // Track the unit register
            if (cfg_mon.valid && cfg_mon.ready)
                unit_ms = cfg_mon.data;

            // Advance the shadow state on a key beat
            if (key_mon.valid && key_mon.ready)
            begin
                predict_item(key_mon.operation, key_mon.now_ms, key_mon.start_addr,
                             key_mon.free_count, key_mon.macro_code);
                items_taken = items_taken + 1;
            end

            writes_outstanding = predicted_writes.size();
        end
    end

endmodule

### bench/tb_keying_duration_recorder_top.sv
// ============================================================================
// tb_keying_duration_recorder_top
// Drives the keying duration recorder with a directed opening and then
// random Morse-like recordings under several unit lengths, with bursty key
// traffic and a stalling record sink; a checker beside the block predicts
// and compares every store write.
// ============================================================================
`timescale 1ns / 1ps

module tb_keying_duration_recorder_top;
    import kdr_pkg::*;

    localparam int     PHASE_ITEMS   = 26;
    localparam int     SETTLE_CYCLES = 48;
    localparam int     END_CYCLES    = 100;
    localparam longint RUN_LIMIT_NS  = 4_000_000;

    // Codes outside the defined operation set
    localparam logic [OP_W-1:0] OP_RSVD_A = 3'd5;
    localparam logic [OP_W-1:0] OP_RSVD_B = 3'd6;
    localparam logic [OP_W-1:0] OP_RSVD_C = 3'd7;

    logic clk = 1'b0;
    logic rst_n;

    kdr_key_if key_ch ();
    kdr_rec_if rec_ch ();
    kdr_cfg_if cfg_ch ();

    int fail_count;
    int writes_outstanding;
    int writes_checked;
    int items_taken;

    int                burst_left;
    int                phase_items;
    int                settings_used;
    logic [UNIT_W-1:0] unit_now;
    logic [TIME_W-1:0] clock_ms;

    // Sink stall pattern state
    int        stall_mode;
    int        mode_timer;
    logic [2:0] cyc;

    keying_duration_recorder_top u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .key_in  (key_ch),
        .rec_out (rec_ch),
        .cfg     (cfg_ch)
    );

    kdr_store_write_checker u_check (
        .clk                (clk),
        .rst_n              (rst_n),
        .key_mon            (key_ch),
        .rec_mon            (rec_ch),
        .cfg_mon            (cfg_ch),
        .fail_count         (fail_count),
        .writes_outstanding (writes_outstanding),
        .writes_checked     (writes_checked),
        .items_taken        (items_taken)
    );

    always #2 clk = ~clk;

    // Stall the record sink in changing modes
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rec_ch.ready <= 1'b0;
            stall_mode   <= 0;
            mode_timer   <= 0;
            cyc          <= '0;
        end
        else
        begin
            cyc <= cyc + 1'b1;
            if (mode_timer == 0)
            begin
                stall_mode <= $urandom_range(0, 3);
                mode_timer <= $urandom_range(20, 200);
            end
            else
                mode_timer <= mode_timer - 1;
            case (stall_mode)
                0:       rec_ch.ready <= 1'b1;
                1:       rec_ch.ready <= ($urandom_range(0, 1) == 1);
                2:       rec_ch.ready <= (cyc[1:0] != 2'd0);
                default: rec_ch.ready <= (cyc < 3'd5);
            endcase
        end
    end

    // Send one key beat, opening a new burst after a random gap
    task automatic send_key(input logic [OP_W-1:0] op, input logic [TIME_W-1:0] now,
                            input logic [ADDR_W-1:0] saddr, input logic [FREE_W-1:0] fcount,
                            input logic [MACRO_W-1:0] mnum);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                key_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        key_ch.valid        <= 1'b1;
        key_ch.operation    <= op;
        key_ch.now_ms       <= now;
        key_ch.start_addr   <= saddr;
        key_ch.free_count   <= fcount;
        key_ch.macro_code   <= mnum;
        do @(posedge clk); while (!key_ch.ready);
        burst_left = burst_left - 1;
    endtask

    // Key beat with random don't-care fields
    task automatic send_edge(input logic [OP_W-1:0] op, input logic [TIME_W-1:0] now);
        send_key(op, now, ADDR_W'($urandom), FREE_W'($urandom_range(0, 1024)),
                 MACRO_W'($urandom));
    endtask

    // Hold the sender until every predicted write has arrived
    task automatic wait_drained();
        key_ch.valid <= 1'b0;
        do @(negedge clk); while (writes_outstanding != 0);
        @(posedge clk);
    endtask

    // Write the unit register while the block is idle
    task automatic write_unit(input logic [UNIT_W-1:0] value);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        unit_now      = value;
        settings_used = settings_used + 1;
    endtask

    // Milliseconds that round to the given units, spread over the rounding window
    function automatic logic [TIME_W-1:0] span_ms(input int unsigned units);
        longint unsigned unit;
        longint unsigned total;
        unit  = (unit_now == '0) ? 1 : unit_now;
        total = longint'(units) * unit + $urandom_range(0, int'(unit) - 1);
        if (total >= unit / 2)
            total = total - unit / 2;
        return TIME_W'(total);
    endfunction

    // Mostly element lengths; some word gaps, fillers and saturation
    function automatic int unsigned pick_units();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return $urandom_range(0, 7);
        else if (r < 75)
            return $urandom_range(3, 12);
        else if (r < 88)
            return $urandom_range(68, 140);
        else if (r < 96)
            return $urandom_range(63, 800);
        else if (r < 99)
            return $urandom_range(800, 4031);
        else
            return $urandom_range(4032, 9000);
    endfunction

    // Any operation code with random fields
    task automatic send_noise();
        send_key(OP_W'($urandom), $urandom, ADDR_W'($urandom),
                 FREE_W'($urandom_range(0, 1024)), MACRO_W'($urandom));
    endtask

    // One start-to-stop recording with random content
    task automatic play_recording();
        logic [ADDR_W-1:0] saddr;
        logic [FREE_W-1:0] fcount;
        int                r;
        r = $urandom_range(0, 99);
        if (r < 15)
            saddr = ADDR_W'(STORE_BYTES_DEF - 1 - $urandom_range(0, 8));
        else
            saddr = ADDR_W'($urandom);
        r = $urandom_range(0, 99);
        if (r < 70)
            fcount = FREE_W'($urandom_range(1, 40));
        else if (r < 85)
            fcount = FREE_W'($urandom_range(0, 1024));
        else if (r < 92)
            fcount = '0;
        else
            fcount = 11'd1024;
        send_key(OP_START, $urandom, saddr, fcount, MACRO_W'($urandom));
        phase_items = phase_items + 1;

        // Skip the opening key down now and then so the first tone runs from zero
        clock_ms = $urandom;
        if ($urandom_range(0, 9) != 0)
        begin
            send_edge(OP_KEY_DOWN, clock_ms);
            phase_items = phase_items + 1;
        end

        repeat ($urandom_range(2, 14))
        begin
            clock_ms = clock_ms + span_ms(pick_units());
            send_edge(OP_KEY_UP, clock_ms);
            phase_items = phase_items + 1;
            if ($urandom_range(0, 5) == 0)
            begin
                send_key(OP_MACRO, $urandom, ADDR_W'($urandom), FREE_W'($urandom),
                         MACRO_W'($urandom));
                phase_items = phase_items + 1;
            end
            if ($urandom_range(0, 11) == 0)
                send_noise();
            clock_ms = clock_ms + span_ms(pick_units());
            send_edge(OP_KEY_DOWN, clock_ms);
            phase_items = phase_items + 1;
        end

        if ($urandom_range(0, 9) != 0)
        begin
            send_edge(OP_STOP, $urandom);
            phase_items = phase_items + 1;
        end
    endtask

    task automatic run_phase();
        phase_items = 0;
        while (phase_items < PHASE_ITEMS)
        begin
            play_recording();
            if ($urandom_range(0, 7) == 0)
                wait_drained();
        end
    endtask

    // Stop a hung run
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("FAIL keying_duration_recorder_top");
        $finish;
    end

    initial
    begin
        rst_n               <= 1'b0;
        key_ch.valid        <= 1'b0;
        key_ch.operation    <= OP_START;
        key_ch.now_ms       <= '0;
        key_ch.start_addr   <= '0;
        key_ch.free_count   <= '0;
        key_ch.macro_code   <= '0;
        cfg_ch.valid        <= 1'b0;
        cfg_ch.data         <= '0;
        burst_left    = 0;
        settings_used = 1;
        unit_now      = UNIT_RESET;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Items outside a recording write nothing
        send_key(OP_KEY_UP, 32'd1000, '0, '0, '0);
        send_key(OP_MACRO, '0, '0, '0, 6'd63);
        send_key(OP_STOP, '0, '0, '0, '0);
        send_key(OP_RSVD_A, '1, '1, '1, '1);
        send_key(OP_RSVD_B, '1, '1, 11'd1024, '1);
        send_key(OP_RSVD_C, '0, '0, '0, '0);

        // Full store; first tone from time zero saturates
        send_key(OP_START, '0, '0, 11'd1024, '0);
        send_key(OP_KEY_UP, 32'hffff_ffff, '0, '0, '0);
        // Time wraps; one unit, then a zero-unit tone
        send_key(OP_KEY_DOWN, 32'd30, '0, '0, '0);
        send_key(OP_KEY_UP, 32'd59, '0, '0, '0);
        // Long pause marks a word start, then a short word
        send_key(OP_KEY_DOWN, 32'd59 + 32'd4500, '0, '0, '0);
        send_key(OP_KEY_UP, 32'd4559 + 32'd180, '0, '0, '0);
        send_key(OP_KEY_DOWN, 32'd4739 + 32'd180, '0, '0, '0);
        send_key(OP_KEY_UP, 32'd4919 + 32'd60, '0, '0, '0);
        send_key(OP_MACRO, '0, '0, '0, 6'd63);
        send_key(OP_MACRO, '0, '0, '0, 6'd0);
        // Exactly 70 units is not a long pause
        send_key(OP_KEY_DOWN, 32'd4979 + 32'd4200, '0, '0, '0);
        send_key(OP_STOP, '0, '0, '0, '0);
        send_key(OP_KEY_DOWN, 32'd20000, '0, '0, '0);
        send_key(OP_MACRO, '0, '0, '0, 6'd5);

        // Last address leaves no room but the terminator
        send_key(OP_START, '0, 10'd1023, 11'd1024, '0);
        send_key(OP_KEY_UP, 32'd500, '0, '0, '0);
        send_key(OP_STOP, '0, '0, '0, '0);

        // Bytes run out inside the fillers
        send_key(OP_START, '0, 10'd1000, 11'd5, '0);
        send_key(OP_KEY_DOWN, 32'd100, '0, '0, '0);
        send_key(OP_KEY_UP, 32'd100 + 32'd12000, '0, '0, '0);
        send_key(OP_KEY_DOWN, 32'd12100 + 32'd30000, '0, '0, '0);
        send_key(OP_STOP, '0, '0, '0, '0);

        // Random recordings under each unit length
        run_phase();
        write_unit(16'd1);
        run_phase();
        write_unit(16'hffff);
        run_phase();
        write_unit(16'd0);
        run_phase();
        write_unit(UNIT_W'($urandom_range(2, 400)));
        run_phase();
        write_unit(UNIT_RESET);
        run_phase();

        // Drain and let any trailing work finish
        wait_drained();
        repeat (END_CYCLES) @(posedge clk);
        @(negedge clk);

        $display("Covered %0d key beats and %0d checked store writes over %0d unit settings,",
                 items_taken, writes_checked, settings_used);
        $display("including saturated durations, time wrap, word marks, macros and stops.");
        if (fail_count == 0 && writes_outstanding == 0)
            $display("PASS keying_duration_recorder_top");
        else
            $display("FAIL keying_duration_recorder_top");
        $finish;
    end

endmodule

### keying_duration_recorder_top.f
hdl/kdr_pkg.sv
hdl/kdr_ifs.sv
hdl/kdr_div.sv
hdl/kdr_seq.sv
hdl/keying_duration_recorder_top.sv
bench/kdr_store_write_checker.sv
bench/tb_keying_duration_recorder_top.sv
